### rtl/rsm_pkg.sv
package rsm_pkg;

    localparam int WORD_TARGETS = 64;
    localparam int BIT_W        = 6;
    localparam int WORD_W       = 4;
    localparam int IDX_W        = WORD_W + BIT_W;
    localparam int SPAN_W       = IDX_W + 1;
    localparam int COUNT_W      = 7;
    localparam int QNUM_W       = 16;
    localparam int RECORD_W     = 64;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    typedef struct packed {
        logic                func;
        logic [RECORD_W-1:0] record;
    } item_t;

    typedef struct packed {
        logic [QNUM_W-1:0]       query_number;
        logic [WORD_W-1:0]       word_index;
        logic [WORD_TARGETS-1:0] contain_mask;
        logic [WORD_TARGETS-1:0] equal_mask;
        logic [COUNT_W-1:0]      match_count;
        logic                    last;
    } result_t;

    // control from the sequencer to the word accumulator
    typedef struct packed {
        logic             rd_en;
        logic [BIT_W-1:0] bit_pos;
        logic             clear;
    } acc_ctrl_t;

endpackage

### rtl/rsm_stream_if.sv
interface rsm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/record_superset_matcher.sv
// record_superset_matcher: containment and equality test of query records
// against a table of stored target records
//
// channels: items (sink) carries func and record; func load stores the
// record in the next free slot of the target memory, func query starts a
// scan over all stored targets. results (source) returns one transaction per
// group of 64 targets: containment mask, equality mask, match count, last.
//
// a load into a full table is dropped. a query over the stored targets
// is handled group by group of 64 targets: the scan state reads one target
// per cycle from the read port of the target memory, the drain state compares
// the final read, and the emit state hands the group to the output register,
// waiting there while the receiver stalls; with no targets stored it yields
// a single empty result. items is ready only while the sequencer is idle,
// not while a query is being handled.
//
// reset clears the loaded count and the query counter; the target memory
// keeps no reset value and only written slots are ever read. a stalled
// receiver holds the scan at the end of the current group.
module record_superset_matcher #(
    parameter int RECORD_BYTES = 8,
    parameter int MAX_TARGETS  = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    rsm_stream_if.sink          items,
    rsm_stream_if.source        results
);

    localparam int REC_W  = 8 * RECORD_BYTES;
    localparam int ADDR_W = $clog2(MAX_TARGETS);
    localparam int CNT_W  = $clog2(MAX_TARGETS + 1);

    // sequencer state
    rsm_pkg::state_t                   state_reg, state_next;
    logic [CNT_W-1:0]                  loaded_reg, loaded_next;
    logic [rsm_pkg::QNUM_W-1:0]        qcnt_reg, qcnt_next;
    logic [rsm_pkg::QNUM_W-1:0]        qnum_reg, qnum_next;
    logic [rsm_pkg::WORD_W-1:0]        word_reg, word_next;
    logic [rsm_pkg::BIT_W-1:0]         bit_reg, bit_next;
    logic                              last_reg, last_next;
    logic [REC_W-1:0]                  qrec_reg, qrec_next;

    // output register
    logic                              out_vld_reg, out_vld_next;
    rsm_pkg::result_t                  out_reg;

    logic                              in_take;
    logic                              wr_en;
    logic                              out_free;
    logic                              out_load;
    logic                              rd_en;
    logic [rsm_pkg::IDX_W-1:0]         scan_addr;
    logic                              end_of_data;
    logic                              word_end;
    logic [REC_W-1:0]                  in_rec;
    logic [REC_W-1:0]                  target;
    rsm_pkg::acc_ctrl_t                acc_ctrl;
    logic [rsm_pkg::WORD_TARGETS-1:0]  contain_mask;
    logic [rsm_pkg::WORD_TARGETS-1:0]  equal_mask;
    logic [rsm_pkg::COUNT_W-1:0]       match_count;

    assign items.ready = (state_reg == rsm_pkg::ST_IDLE);
    assign in_take     = items.valid && items.ready;
    assign in_rec      = items.data.record[REC_W-1:0];

    // loads only happen while idle and reads only during a scan, so the
    // memory never sees a write and a read of the same slot together
    assign wr_en = in_take && (items.data.func == rsm_pkg::FUNC_LOAD)
                   && (loaded_reg < CNT_W'(MAX_TARGETS));

    // target slot of the current read: group number above position in group
    assign scan_addr   = {word_reg, bit_reg};
    assign end_of_data = (rsm_pkg::SPAN_W'(scan_addr) + rsm_pkg::SPAN_W'(1))
                         == rsm_pkg::SPAN_W'(loaded_reg);
    assign word_end    = end_of_data || (bit_reg == '1);

    assign out_free = !out_vld_reg || results.ready;

    always_comb
    begin
        state_next  = state_reg;
        loaded_next = loaded_reg;
        qcnt_next   = qcnt_reg;
        qnum_next   = qnum_reg;
        word_next   = word_reg;
        bit_next    = bit_reg;
        last_next   = last_reg;
        qrec_next   = qrec_reg;
        rd_en       = 1'b0;
        out_load    = 1'b0;

        if (wr_en)
        begin
            loaded_next = loaded_reg + CNT_W'(1);
        end

        unique case (state_reg)
            rsm_pkg::ST_IDLE:
            begin
                if (in_take && (items.data.func == rsm_pkg::FUNC_QUERY))
                begin
                    qrec_next = in_rec;
                    qnum_next = qcnt_reg;
                    qcnt_next = qcnt_reg + rsm_pkg::QNUM_W'(1);
                    word_next = '0;
                    bit_next  = '0;
                    if (loaded_reg == '0)
                    begin
                        // empty table: one empty final result
                        last_next  = 1'b1;
                        state_next = rsm_pkg::ST_EMIT;
                    end
                    else
                    begin
                        last_next  = 1'b0;
                        state_next = rsm_pkg::ST_SCAN;
                    end
                end
            end
            rsm_pkg::ST_SCAN:
            begin
                rd_en    = 1'b1;
                bit_next = bit_reg + rsm_pkg::BIT_W'(1);
                if (word_end)
                begin
                    last_next  = end_of_data;
                    state_next = rsm_pkg::ST_DRAIN;
                end
            end
            rsm_pkg::ST_DRAIN:
            begin
                // final read of the group is compared here
                state_next = rsm_pkg::ST_EMIT;
            end
            rsm_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (last_reg)
                    begin
                        state_next = rsm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        word_next  = word_reg + rsm_pkg::WORD_W'(1);
                        bit_next   = '0;
                        state_next = rsm_pkg::ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = rsm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    assign acc_ctrl.rd_en   = rd_en;
    assign acc_ctrl.bit_pos = bit_reg;
    assign acc_ctrl.clear   = out_load;

    rsm_target_mem #(
        .DEPTH  (MAX_TARGETS),
        .ADDR_W (ADDR_W),
        .DATA_W (REC_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (loaded_reg[ADDR_W-1:0]),
        .wr_data (in_rec),
        .rd_en   (rd_en),
        .rd_addr (scan_addr[ADDR_W-1:0]),
        .rd_data (target)
    );

    rsm_word_acc #(
        .REC_W (REC_W)
    ) u_acc (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (acc_ctrl),
        .query        (qrec_reg),
        .target       (target),
        .contain_mask (contain_mask),
        .equal_mask   (equal_mask),
        .match_count  (match_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rsm_pkg::ST_IDLE;
            loaded_reg  <= '0;
            qcnt_reg    <= '0;
            qnum_reg    <= '0;
            word_reg    <= '0;
            bit_reg     <= '0;
            last_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            loaded_reg  <= loaded_next;
            qcnt_reg    <= qcnt_next;
            qnum_reg    <= qnum_next;
            word_reg    <= word_next;
            bit_reg     <= bit_next;
            last_reg    <= last_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        qrec_reg <= qrec_next;
        if (out_load)
        begin
            out_reg.query_number <= qnum_reg;
            out_reg.word_index   <= word_reg;
            out_reg.contain_mask <= contain_mask;
            out_reg.equal_mask   <= equal_mask;
            out_reg.match_count  <= match_count;
            out_reg.last         <= last_reg;
        end
    end

    assign results.valid = out_vld_reg;
    assign results.data  = out_reg;

endmodule

### rtl/rsm_target_mem.sv
module rsm_target_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 64
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/rsm_word_acc.sv
module rsm_word_acc #(
    parameter int REC_W = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rsm_pkg::acc_ctrl_t                     ctrl,
    input  logic [REC_W-1:0]                       query,
    input  logic [REC_W-1:0]                       target,
    output logic [rsm_pkg::WORD_TARGETS-1:0]       contain_mask,
    output logic [rsm_pkg::WORD_TARGETS-1:0]       equal_mask,
    output logic [rsm_pkg::COUNT_W-1:0]            match_count
);

    logic                                vld_reg;
    logic [rsm_pkg::BIT_W-1:0]           bit_reg;
    logic [rsm_pkg::WORD_TARGETS-1:0]    contain_reg, contain_next;
    logic [rsm_pkg::WORD_TARGETS-1:0]    equal_reg, equal_next;
    logic [rsm_pkg::COUNT_W-1:0]         count_reg, count_next;
    logic                                hit;
    logic                                same;

    // target data arrives in the cycle after the read was issued
    assign hit  = vld_reg && ((query & ~target) == '0);
    assign same = vld_reg && (query == target);

    always_comb
    begin
        contain_next = contain_reg;
        equal_next   = equal_reg;
        count_next   = count_reg;
        if (ctrl.clear)
        begin
            contain_next = '0;
            equal_next   = '0;
            count_next   = '0;
        end
        else if (vld_reg)
        begin
            contain_next = contain_reg
                | (rsm_pkg::WORD_TARGETS'(hit) << bit_reg);
            equal_next   = equal_reg
                | (rsm_pkg::WORD_TARGETS'(same) << bit_reg);
            count_next   = count_reg + rsm_pkg::COUNT_W'(hit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= 1'b0;
            bit_reg     <= '0;
            contain_reg <= '0;
            equal_reg   <= '0;
            count_reg   <= '0;
        end
        else
        begin
            vld_reg     <= ctrl.rd_en;
            bit_reg     <= ctrl.bit_pos;
            contain_reg <= contain_next;
            equal_reg   <= equal_next;
            count_reg   <= count_next;
        end
    end

    assign contain_mask = contain_reg;
    assign equal_mask   = equal_reg;
    assign match_count  = count_reg;

endmodule

### rtl/rsm_checker.sv
module rsm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       res_valid,
    input logic                       res_ready,
    input rsm_pkg::result_t           res_data
);

    // a stalled result transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // an equal target is always a containing target
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_data.equal_mask & ~res_data.contain_mask) == '0))
        else $error("equal bit without contain bit");

    // count agrees with the containment mask
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.match_count
                       == rsm_pkg::COUNT_W'($countones(res_data.contain_mask))))
        else $error("match count does not agree with mask");

    // a group with the highest word index is always marked last
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.last |-> res_data.word_index != '1)
        else $error("group after the final group");

endmodule

bind record_superset_matcher rsm_checker u_rsm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_data  (results.data)
);

### test/record_superset_matcher_tb.sv
module record_superset_matcher_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // block configuration, default sizes
    localparam int RB    = 8;
    localparam int MAX_T = 1024;

    // stimulus sizes
    localparam int N_RANDOM    = 410;
    localparam int N_DIRECTED  = 18;
    localparam int LONG_HOLD   = 400;     // receiver hold-off, in cycles
    localparam int TAIL_CYCLES = 64;      // settle time after the last result
    localparam int CYCLE_LIMIT = 1500000; // watchdog

    // one row of the directed table; typed rows carry a single-word result
    typedef struct packed {
        logic                             func;
        logic [rsm_pkg::RECORD_W-1:0]     rec;
        bit                               typed;
        logic [rsm_pkg::QNUM_W-1:0]       qn;
        logic [rsm_pkg::WORD_TARGETS-1:0] cm;
        logic [rsm_pkg::WORD_TARGETS-1:0] em;
        logic [rsm_pkg::COUNT_W-1:0]      cnt;
    } dir_row_t;

    // what the sender attaches to each transaction it offers
    typedef struct packed {
        bit               typed;
        rsm_pkg::result_t res;
    } item_note_t;

    logic clk;
    logic rst_n;

    rsm_stream_if #(.payload_t(rsm_pkg::item_t))   items_ch ();
    rsm_stream_if #(.payload_t(rsm_pkg::result_t)) results_ch ();

    record_superset_matcher #(
        .RECORD_BYTES(RB),
        .MAX_TARGETS (MAX_T)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (items_ch),
        .results(results_ch)
    );

    // predictor state: a private copy of the target table and counters
    logic [rsm_pkg::RECORD_W-1:0] target_copy [0:MAX_T-1];
    int                           target_total;
    logic [rsm_pkg::QNUM_W-1:0]   next_query_num;

    // word results of the last predicted item, and the words still awaited
    rsm_pkg::result_t predicted_words [$];
    rsm_pkg::result_t awaited_words [$];
    item_note_t       item_notes [$];

    dir_row_t dir_rows [0:N_DIRECTED-1];

    int  error_count;
    int  items_accepted;
    int  queries_accepted;
    int  loads_dropped;
    int  words_checked;
    int  loads_issued;
    int  cycle_count;

    // idling and pressure controls shared by the sender and the receiver
    bit  tx_idle_on;
    bit  rx_idle_on;
    bit  long_hold_req;

    // ------------------------------------------------------------------
    // clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d words still awaited",
                         cycle_count, awaited_words.size());
                $display("record_superset_matcher_tb failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                   input logic [63:0] exp_v);
        error_count++;
        $display("mismatch at cycle %0d: %s got %h expected %h",
                 cycle_count, what, got_v, exp_v);
    endtask

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [rsm_pkg::RECORD_W-1:0] record_bits();
        if (RB >= 8)
            return '1;
        return (64'(1) << (8 * RB)) - 64'(1);
    endfunction

    // updates the table copy; for a query fills predicted_words with one
    // word result per group of 64 stored targets
    function automatic void predict_item(input rsm_pkg::item_t it);
        logic [rsm_pkg::RECORD_W-1:0]     rec;
        logic [rsm_pkg::RECORD_W-1:0]     tgt;
        logic [rsm_pkg::WORD_TARGETS-1:0] cm;
        logic [rsm_pkg::WORD_TARGETS-1:0] em;
        rsm_pkg::result_t                 r;
        int                               words;
        int                               j;

        predicted_words.delete();
        rec = it.record & record_bits();
        if (it.func == rsm_pkg::FUNC_LOAD)
        begin
            // a full table drops the load
            if (target_total < MAX_T)
            begin
                target_copy[target_total] = rec;
                target_total++;
            end
            else
                loads_dropped++;
            return;
        end

        words = (target_total + rsm_pkg::WORD_TARGETS - 1) / rsm_pkg::WORD_TARGETS;
        // an empty table still answers with one empty word
        if (words == 0)
            words = 1;
        for (int w = 0; w < words; w++)
        begin
            cm = '0;
            em = '0;
            for (int b = 0; b < rsm_pkg::WORD_TARGETS; b++)
            begin
                j = w * rsm_pkg::WORD_TARGETS + b;
                if (j < target_total)
                begin
                    tgt = target_copy[j];
                    if ((rec & ~tgt) == '0)
                        cm[b] = 1'b1;
                    if (rec == tgt)
                        em[b] = 1'b1;
                end
            end
            r.query_number = next_query_num;
            r.word_index   = rsm_pkg::WORD_W'(w);
            r.contain_mask = cm;
            r.equal_mask   = em;
            r.match_count  = rsm_pkg::COUNT_W'($countones(cm));
            r.last         = (w + 1 == words);
            predicted_words = {predicted_words, r};
        end
        next_query_num++;
    endfunction

    // ------------------------------------------------------------------
    // monitor: checks result transactions, predicts item transactions
    // ------------------------------------------------------------------
    task automatic check_word(input rsm_pkg::result_t got);
        rsm_pkg::result_t exp_w;
        if (awaited_words.size() == 0)
        begin
            report_mismatch("result with none awaited, query_number",
                            64'(got.query_number), 64'(0));
            return;
        end
        exp_w = awaited_words.pop_front();
        words_checked++;
        if (got.query_number !== exp_w.query_number)
            report_mismatch("query_number", 64'(got.query_number),
                            64'(exp_w.query_number));
        if (got.word_index !== exp_w.word_index)
            report_mismatch("word_index", 64'(got.word_index), 64'(exp_w.word_index));
        if (got.contain_mask !== exp_w.contain_mask)
            report_mismatch("contain_mask", got.contain_mask, exp_w.contain_mask);
        if (got.equal_mask !== exp_w.equal_mask)
            report_mismatch("equal_mask", got.equal_mask, exp_w.equal_mask);
        if (got.match_count !== exp_w.match_count)
            report_mismatch("match_count", 64'(got.match_count), 64'(exp_w.match_count));
        if (got.last !== exp_w.last)
            report_mismatch("last", 64'(got.last), 64'(exp_w.last));
    endtask

    task automatic absorb_item(input rsm_pkg::item_t it);
        item_note_t note;
        note = '0;
        if (item_notes.size() != 0)
            note = item_notes.pop_front();
        items_accepted++;
        if (it.func == rsm_pkg::FUNC_QUERY)
            queries_accepted++;
        predict_item(it);
        // typed rows replace the predicted word, the table copy still moves on
        if (note.typed && it.func == rsm_pkg::FUNC_QUERY)
            awaited_words = {awaited_words, note.res};
        else
            foreach (predicted_words[k])
                awaited_words = {awaited_words, predicted_words[k]};
    endtask

    // sampled at the edge, before any nonblocking update of this step
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (results_ch.valid && results_ch.ready)
                check_word(results_ch.data);
            if (items_ch.valid && items_ch.ready)
                absorb_item(items_ch.data);
        end
    end

    // ------------------------------------------------------------------
    // receiver: random hold-off bursts, one long hold on request
    // ------------------------------------------------------------------
    initial
    begin
        results_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                // long stretch so the block backs up into its input
                long_hold_req = 1'b0;
                results_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                results_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                results_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // offers one transaction and waits for acceptance; may idle afterwards
    task automatic send_item(input rsm_pkg::item_t it, input bit typed,
                             input rsm_pkg::result_t res);
        item_note_t note;
        note.typed = typed;
        note.res   = res;
        item_notes = {item_notes, note};
        if (it.func == rsm_pkg::FUNC_LOAD)
            loads_issued++;
        items_ch.data  <= it;
        items_ch.valid <= 1'b1;
        @(posedge clk);
        while (!items_ch.ready)
            @(posedge clk);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            items_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic send_plain(input rsm_pkg::item_t it);
        send_item(it, 1'b0, '0);
    endtask

    // waits until every awaited word has come back
    task automatic wait_drained();
        items_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_words.size() != 0)
            @(posedge clk);
    endtask

    function automatic rsm_pkg::item_t random_load();
        rsm_pkg::item_t it;
        int             pick;
        logic [63:0]    base;
        pick = $urandom_range(0, 99);
        base = (target_total > 0) ? target_copy[$urandom_range(0, target_total - 1)]
                                  : rand64();
        it.func = rsm_pkg::FUNC_LOAD;
        if (pick < 40)
            it.record = rand64();
        else if (pick < 70)
            it.record = base | (rand64() & rand64());   // superset of a stored one
        else if (pick < 85)
            it.record = base;                            // duplicate target
        else
            it.record = rand64() & rand64() & rand64();  // sparse
        return it;
    endfunction

    function automatic rsm_pkg::item_t random_query();
        rsm_pkg::item_t it;
        int             pick;
        logic [63:0]    base;
        pick = $urandom_range(0, 99);
        base = (target_total > 0) ? target_copy[$urandom_range(0, target_total - 1)]
                                  : rand64();
        it.func = rsm_pkg::FUNC_QUERY;
        if (pick < 30)
            it.record = base;                            // equal to a target
        else if (pick < 60)
            it.record = base & rand64();                 // contained subset
        else if (pick < 80)
            it.record = rand64() & rand64() & rand64() & rand64();
        else
            it.record = rand64();                        // noise
        return it;
    endfunction

    function automatic dir_row_t row(input logic func, input logic [63:0] rec,
                                     input bit typed, input logic [15:0] qn,
                                     input logic [63:0] cm, input logic [63:0] em,
                                     input logic [6:0] cnt);
        dir_row_t r;
        r.func  = func;
        r.rec   = rec;
        r.typed = typed;
        r.qn    = qn;
        r.cm    = cm;
        r.em    = em;
        r.cnt   = cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rsm_pkg::item_t   it;
        rsm_pkg::result_t res;

        error_count      = 0;
        items_accepted   = 0;
        queries_accepted = 0;
        loads_dropped    = 0;
        words_checked    = 0;
        loads_issued     = 0;
        target_total     = 0;
        next_query_num   = '0;
        tx_idle_on       = 1'b1;
        rx_idle_on       = 1'b1;
        long_hold_req    = 1'b0;

        // directed table: empty table first, then extremes and bit patterns
        dir_rows[0]  = row(rsm_pkg::FUNC_QUERY, 64'h0, 1'b1, 16'd0,
                           64'h0, 64'h0, 7'd0);
        dir_rows[1]  = row(rsm_pkg::FUNC_QUERY, '1, 1'b1, 16'd1,
                           64'h0, 64'h0, 7'd0);
        dir_rows[2]  = row(rsm_pkg::FUNC_LOAD, 64'h0, 1'b0, 16'd0,
                           64'h0, 64'h0, 7'd0);
        dir_rows[3]  = row(rsm_pkg::FUNC_LOAD, '1, 1'b0, 16'd0,
                           64'h0, 64'h0, 7'd0);
        dir_rows[4]  = row(rsm_pkg::FUNC_QUERY, 64'h0, 1'b1, 16'd2,
                           64'h3, 64'h1, 7'd2);
        dir_rows[5]  = row(rsm_pkg::FUNC_QUERY, '1, 1'b1, 16'd3,
                           64'h2, 64'h2, 7'd1);
        dir_rows[6]  = row(rsm_pkg::FUNC_LOAD, 64'h0000_0000_0000_00ff, 1'b0, 16'd0,
                           64'h0, 64'h0, 7'd0);
        dir_rows[7]  = row(rsm_pkg::FUNC_LOAD, 64'h8000_0000_0000_0001, 1'b0, 16'd0,
                           64'h0, 64'h0, 7'd0);
        dir_rows[8]  = row(rsm_pkg::FUNC_QUERY, 64'h1, 1'b1, 16'd4,
                           64'he, 64'h0, 7'd3);
        dir_rows[9]  = row(rsm_pkg::FUNC_QUERY, 64'h8000_0000_0000_0000, 1'b1, 16'd5,
                           64'ha, 64'h0, 7'd2);
        dir_rows[10] = row(rsm_pkg::FUNC_QUERY, 64'h8000_0000_0000_0001, 1'b1, 16'd6,
                           64'ha, 64'h8, 7'd2);
        dir_rows[11] = row(rsm_pkg::FUNC_LOAD, 64'h5555_5555_5555_5555, 1'b0, 16'd0,
                           64'h0, 64'h0, 7'd0);
        dir_rows[12] = row(rsm_pkg::FUNC_LOAD, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 16'd0,
                           64'h0, 64'h0, 7'd0);
        dir_rows[13] = row(rsm_pkg::FUNC_QUERY, 64'h5555_5555_5555_5555, 1'b1, 16'd7,
                           64'h12, 64'h10, 7'd2);
        dir_rows[14] = row(rsm_pkg::FUNC_QUERY, 64'haaaa_aaaa_aaaa_aaaa, 1'b1, 16'd8,
                           64'h22, 64'h20, 7'd2);
        dir_rows[15] = row(rsm_pkg::FUNC_QUERY, 64'hffff_ffff_ffff_fffe, 1'b1, 16'd9,
                           64'h2, 64'h0, 7'd1);
        dir_rows[16] = row(rsm_pkg::FUNC_QUERY, 64'h0000_0000_0000_00f0, 1'b0, 16'd0,
                           64'h0, 64'h0, 7'd0);
        dir_rows[17] = row(rsm_pkg::FUNC_QUERY, 64'h0, 1'b1, 16'd11,
                           64'h3f, 64'h1, 7'd6);

        items_ch.valid <= 1'b0;
        items_ch.data  <= '0;
        rst_n          <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            it.func   = dir_rows[i].func;
            it.record = dir_rows[i].rec;
            res = '{query_number: dir_rows[i].qn, word_index: '0,
                    contain_mask: dir_rows[i].cm, equal_mask: dir_rows[i].em,
                    match_count: dir_rows[i].cnt, last: 1'b1};
            send_item(it, dir_rows[i].typed, res);
        end
        wait_drained();

        // random part: the table grows gradually, queries shaped to hit
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 150)
            begin
                // stall the receiver, keep offering so the input backs up
                long_hold_req = 1'b1;
                send_plain(random_query());
            end
            else if (i == 300)
            begin
                // sender pause until everything has come back
                wait_drained();
                send_plain(random_query());
            end
            else if ($urandom_range(0, 99) < 45)
                send_plain(random_load());
            else
                send_plain(random_query());
        end

        // extreme queries over the whole table
        it.func   = rsm_pkg::FUNC_QUERY;
        it.record = '1;
        send_plain(it);
        it.record = '0;
        send_plain(it);
        wait_drained();

        // last part without idling on either side
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (i % 2 == 0)
                send_plain(random_load());
            else
                send_plain(random_query());
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (awaited_words.size() != 0)
            report_mismatch("words left over at end", 64'(awaited_words.size()), 64'(0));

        $display("covered %0d item transactions (%0d queries, %0d loads offered, %0d dropped)",
                 items_accepted, queries_accepted, loads_issued, loads_dropped);
        $display("checked %0d result transactions, %0d of %0d targets stored, %0d errors",
                 words_checked, target_total, MAX_T, error_count);
        if (error_count == 0)
            $display("record_superset_matcher_tb passed");
        else
            $display("record_superset_matcher_tb failed");
        $finish;
    end

endmodule

### filelist.f
rtl/rsm_pkg.sv
rtl/rsm_stream_if.sv
rtl/rsm_target_mem.sv
rtl/rsm_word_acc.sv
rtl/record_superset_matcher.sv
rtl/rsm_checker.sv
test/record_superset_matcher_tb.sv
